### rtl/tse_pkg.sv
// Package for the triangle element stiffness block: result format constants
// and the map from unique matrix entries to rows and columns. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tse_pkg;
   localparam int OUT_WIDTH = 32;
   localparam int OUT_FRAC  = 16;
   // The matrix is symmetric, so only the upper triangle is computed.
   localparam int NUM_ENT   = 6;
   localparam int ENT_ROW [NUM_ENT] = '{0, 0, 0, 1, 1, 2};
   localparam int ENT_COL [NUM_ENT] = '{0, 1, 2, 1, 2, 2};
   localparam logic [OUT_WIDTH-1:0] SAT_POS = {1'b0, {(OUT_WIDTH-1){1'b1}}};
   localparam logic [OUT_WIDTH-1:0] SAT_NEG = {1'b1, {(OUT_WIDTH-1){1'b0}}};
endpackage
`default_nettype wire

### rtl/tse_if.sv
// Valid/ready channel interfaces for the triangle element stiffness block.
// Depends on tse_pkg for the result entry width.
`timescale 1ns / 1ps
`default_nettype none
interface tse_req_if #(parameter int COORD_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] x0;
   logic signed [COORD_WIDTH-1:0] y0;
   logic signed [COORD_WIDTH-1:0] x1;
   logic signed [COORD_WIDTH-1:0] y1;
   logic signed [COORD_WIDTH-1:0] x2;
   logic signed [COORD_WIDTH-1:0] y2;
   modport source (output valid, x0, y0, x1, y1, x2, y2, input ready);
   modport sink   (input valid, x0, y0, x1, y1, x2, y2, output ready);
endinterface

interface tse_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [tse_pkg::OUT_WIDTH-1:0]     k00, k01, k02;
   logic signed [tse_pkg::OUT_WIDTH-1:0]     k10, k11, k12;
   logic signed [tse_pkg::OUT_WIDTH-1:0]     k20, k21, k22;
   logic                                     degenerate;
   modport source (output valid, k00, k01, k02, k10, k11, k12, k20, k21, k22,
                   degenerate, input ready);
   modport sink   (input valid, k00, k01, k02, k10, k11, k12, k20, k21, k22,
                   degenerate, output ready);
endinterface
`default_nettype wire

### rtl/triangle_element_stiffness.sv
// Top level of the linear triangle element stiffness pipeline.
// Depends on tse_pkg and the channel interfaces in tse_if.sv.
//
//   channel | dir | carries
//   --------+-----+----------------------------------------------
//   req     | in  | one triangle: x0, y0, x1, y1, x2, y2
//   rsp     | out | k00..k22 (Q15.16, saturated) and degenerate
//
// One request enters per clock while rsp is not stalled; the six restoring
// dividers each resolve one quotient bit per stage.
// Reset is synchronous and active high; it clears every stage valid bit.
// The whole pipeline advances only when the output register is empty or is
// being taken, so a stall on rsp holds every stage and nothing is lost.
`timescale 1ns / 1ps
`default_nettype none
module triangle_element_stiffness #(
   parameter int COORD_WIDTH = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   tse_req_if.sink   req,
   tse_rsp_if.source rsp
);
   import tse_pkg::*;

   localparam int DW = COORD_WIDTH + 1;        // edge differences
   localparam int PW = 2 * COORD_WIDTH + 2;    // products
   localparam int SW = 2 * COORD_WIDTH + 3;    // sums of products
   localparam int QB = OUT_WIDTH;              // quotient bits
   localparam int RW = SW + QB + 3;            // remainder and shifted divisor

   logic adv;
   assign adv       = !rsp.valid || rsp.ready;
   assign req.ready = adv;

   // Stage 1: edge differences P and Q.
   logic                 s1_valid_ff;
   logic signed [DW-1:0] p_ff [3];
   logic signed [DW-1:0] q_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req.valid;
      end
      if (adv) begin
         p_ff[0] <= DW'(req.y1) - DW'(req.y2);
         p_ff[1] <= DW'(req.y2) - DW'(req.y0);
         p_ff[2] <= DW'(req.y0) - DW'(req.y1);
         q_ff[0] <= DW'(req.x2) - DW'(req.x1);
         q_ff[1] <= DW'(req.x0) - DW'(req.x2);
         q_ff[2] <= DW'(req.x1) - DW'(req.x0);
      end
   end

   // Stage 2: products for the six unique entries and the area terms.
   logic                 s2_valid_ff;
   logic signed [PW-1:0] pp_ff [NUM_ENT];
   logic signed [PW-1:0] qq_ff [NUM_ENT];
   logic signed [PW-1:0] da_ff, db_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (adv) begin
         for (int e = 0; e < NUM_ENT; e++) begin
            pp_ff[e] <= PW'(p_ff[ENT_ROW[e]]) * PW'(p_ff[ENT_COL[e]]);
            qq_ff[e] <= PW'(q_ff[ENT_ROW[e]]) * PW'(q_ff[ENT_COL[e]]);
         end
         da_ff <= PW'(p_ff[1]) * PW'(q_ff[2]);
         db_ff <= PW'(p_ff[2]) * PW'(q_ff[1]);
      end
   end

   // Stage 3: numerators and twice the signed area.
   logic                 s3_valid_ff;
   logic signed [SW-1:0] num_ff [NUM_ENT];
   logic signed [SW-1:0] den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (adv) begin
         for (int e = 0; e < NUM_ENT; e++) begin
            num_ff[e] <= SW'(pp_ff[e]) + SW'(qq_ff[e]);
         end
         den_ff <= SW'(da_ff) - SW'(db_ff);
      end
   end

   // Stage 4: magnitudes and result signs.
   logic          s4_valid_ff;
   logic [SW-1:0] mn_ff [NUM_ENT];
   logic [SW-1:0] md_ff;
   logic          s4_neg_ff [NUM_ENT];
   logic          s4_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (adv) begin
         for (int e = 0; e < NUM_ENT; e++) begin
            mn_ff[e]     <= num_ff[e][SW-1] ? SW'(-num_ff[e]) : SW'(num_ff[e]);
            s4_neg_ff[e] <= num_ff[e][SW-1] != den_ff[SW-1];
         end
         md_ff     <= den_ff[SW-1] ? SW'(-den_ff) : SW'(den_ff);
         s4_deg_ff <= den_ff == '0;
      end
   end

   // Stage 5: dividend with the rounding half added, and the divisor.
   // q = floor((num * 2^17 + 2*den) / (4*den)) rounds half away from zero.
   logic          s5_valid_ff;
   logic [RW-1:0] nn_ff [NUM_ENT];
   logic [RW-1:0] s5_dv_ff;
   logic          s5_neg_ff [NUM_ENT];
   logic          s5_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (adv) begin
         s5_valid_ff <= s4_valid_ff;
      end
      if (adv) begin
         for (int e = 0; e < NUM_ENT; e++) begin
            nn_ff[e] <= (RW'(mn_ff[e]) << (OUT_FRAC + 1)) + (RW'(md_ff) << 1);
         end
         s5_dv_ff  <= RW'(md_ff) << 2;
         s5_neg_ff <= s4_neg_ff;
         s5_deg_ff <= s4_deg_ff;
      end
   end

   // Divider stage 0 is loaded with the overflow check: a quotient that
   // needs more than QB bits saturates whatever its low bits are.
   logic          dv_valid_ff [QB+1];
   logic [RW-1:0] dr_ff       [QB+1][NUM_ENT];
   logic [QB-1:0] dq_ff       [QB+1][NUM_ENT];
   logic          dovf_ff     [QB+1][NUM_ENT];
   logic          dneg_ff     [QB+1][NUM_ENT];
   logic [RW-1:0] ddv_ff      [QB+1];
   logic          ddeg_ff     [QB+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_valid_ff[0] <= s5_valid_ff;
      end
      if (adv) begin
         for (int e = 0; e < NUM_ENT; e++) begin
            dr_ff[0][e]   <= nn_ff[e];
            dq_ff[0][e]   <= '0;
            dovf_ff[0][e] <= nn_ff[e] >= (s5_dv_ff << QB);
            dneg_ff[0][e] <= s5_neg_ff[e];
         end
         ddv_ff[0]  <= s5_dv_ff;
         ddeg_ff[0] <= s5_deg_ff;
      end
   end

   // One quotient bit per stage, most significant first.
   for (genvar s = 0; s < QB; s++) begin : g_div
      localparam int BIT = QB - 1 - s;
      logic [RW-1:0] shifted_dv;
      assign shifted_dv = ddv_ff[s] << BIT;

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[s+1] <= 1'b0;
         end else if (adv) begin
            dv_valid_ff[s+1] <= dv_valid_ff[s];
         end
         if (adv) begin
            for (int e = 0; e < NUM_ENT; e++) begin
               if (dr_ff[s][e] >= shifted_dv) begin
                  dr_ff[s+1][e] <= dr_ff[s][e] - shifted_dv;
                  dq_ff[s+1][e] <= dq_ff[s][e] | (QB'(1) << BIT);
               end else begin
                  dr_ff[s+1][e] <= dr_ff[s][e];
                  dq_ff[s+1][e] <= dq_ff[s][e];
               end
               dovf_ff[s+1][e] <= dovf_ff[s][e];
               dneg_ff[s+1][e] <= dneg_ff[s][e];
            end
            ddv_ff[s+1]  <= ddv_ff[s];
            ddeg_ff[s+1] <= ddeg_ff[s];
         end
      end
   end

   // Output register: sign, saturation and the zero-area case.
   logic                 out_valid_ff;
   logic [OUT_WIDTH-1:0] out_k_ff [NUM_ENT];
   logic                 out_deg_ff;
   logic [OUT_WIDTH-1:0] out_k_in [NUM_ENT];

   always_comb begin
      for (int e = 0; e < NUM_ENT; e++) begin
         if (ddeg_ff[QB]) begin
            out_k_in[e] = '0;
         end else if (dneg_ff[QB][e]) begin
            if (dovf_ff[QB][e] || dq_ff[QB][e] > SAT_NEG) begin
               out_k_in[e] = SAT_NEG;
            end else begin
               out_k_in[e] = -dq_ff[QB][e];
            end
         end else begin
            if (dovf_ff[QB][e] || dq_ff[QB][e] > SAT_POS) begin
               out_k_in[e] = SAT_POS;
            end else begin
               out_k_in[e] = dq_ff[QB][e];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= dv_valid_ff[QB];
      end
      if (adv) begin
         out_k_ff   <= out_k_in;
         out_deg_ff <= ddeg_ff[QB];
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.degenerate = out_deg_ff;
   assign rsp.k00        = out_k_ff[0];
   assign rsp.k01        = out_k_ff[1];
   assign rsp.k02        = out_k_ff[2];
   assign rsp.k10        = out_k_ff[1];
   assign rsp.k11        = out_k_ff[3];
   assign rsp.k12        = out_k_ff[4];
   assign rsp.k20        = out_k_ff[2];
   assign rsp.k21        = out_k_ff[4];
   assign rsp.k22        = out_k_ff[5];
endmodule
`default_nettype wire

### rtl/tse_checker.sv
// Port-level checks for triangle_element_stiffness, bound to the top level.
// Depends on tse_pkg for the entry width.
`timescale 1ns / 1ps
`default_nettype none
module tse_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic                             degenerate,
   input wire logic signed [tse_pkg::OUT_WIDTH-1:0] k00, k01, k02,
   input wire logic signed [tse_pkg::OUT_WIDTH-1:0] k10, k11, k12,
   input wire logic signed [tse_pkg::OUT_WIDTH-1:0] k20, k21, k22
);
   import tse_pkg::*;

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid) else $error("response valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(k00) && $stable(k12)
      && $stable(degenerate)) else $error("stalled response changed");

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && degenerate |-> k00 == 0 && k01 == 0 && k02 == 0 && k11 == 0
      && k12 == 0 && k22 == 0) else $error("degenerate triangle with nonzero entries");

   a_symmetric: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> k01 == k10 && k02 == k20 && k12 == k21)
      else $error("stiffness matrix not symmetric");

   a_diag_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !degenerate |-> k00 != 0 && k00[OUT_WIDTH-1] == k11[OUT_WIDTH-1]
      && k11[OUT_WIDTH-1] == k22[OUT_WIDTH-1]) else $error("diagonal signs disagree");
endmodule

bind triangle_element_stiffness tse_checker u_tse_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .degenerate (rsp.degenerate),
   .k00 (rsp.k00), .k01 (rsp.k01), .k02 (rsp.k02),
   .k10 (rsp.k10), .k11 (rsp.k11), .k12 (rsp.k12),
   .k20 (rsp.k20), .k21 (rsp.k21), .k22 (rsp.k22)
);
`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for triangle_element_stiffness: random and directed
// triangles, a stiffness predictor and an in-order scoreboard.
// Depends on tse_pkg, the channel interfaces in tse_if.sv and the RTL top.
`timescale 1ns / 1ps

module tb_top;
   import tse_pkg::*;

   localparam int CW         = 16;
   localparam int CLK_PERIOD = 20;
   // The pipeline is OUT_WIDTH + 7 deep; allow some margin after the last item.
   localparam int DRAIN_CYCLES = OUT_WIDTH + 40;
   // A stall counted by the watchdog must cover the long receiver hold-off.
   localparam int IDLE_LIMIT   = 4000;
   localparam int NUM_RANDOM   = 1200;
   localparam int HOLD_AT      = 300;
   localparam int HOLD_CYCLES  = 400;

   // One triangle as the block sees it.
   typedef struct {
      logic signed [CW-1:0] x0, y0, x1, y1, x2, y2;
   } triangle_type;

   // One stiffness matrix in row-major order plus the zero-area flag.
   typedef struct {
      logic signed [OUT_WIDTH-1:0] k [9];
      logic                        degenerate;
   } stiffness_type;

   // Computes the element matrix of one triangle. Entry (i,j) is
   // (Pi*Pj + Qi*Qj) / (2*D) in Q15.16, rounded half away from zero and
   // saturated. All intermediate values fit easily into 64 bits.
   function automatic stiffness_type stiffness_of(triangle_type t);
      stiffness_type res;
      longint     p [3];
      longint     q [3];
      longint     twice_area, num, mag_num, mag_area, quo;
      bit         negative;
      p[0] = longint'(t.y1) - longint'(t.y2);
      p[1] = longint'(t.y2) - longint'(t.y0);
      p[2] = longint'(t.y0) - longint'(t.y1);
      q[0] = longint'(t.x2) - longint'(t.x1);
      q[1] = longint'(t.x0) - longint'(t.x2);
      q[2] = longint'(t.x1) - longint'(t.x0);
      twice_area = p[1] * q[2] - p[2] * q[1];
      res.degenerate = (twice_area == 0);
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if (res.degenerate) begin
               res.k[i*3+j] = '0;
               continue;
            end
            num      = p[i] * p[j] + q[i] * q[j];
            negative = (num < 0) != (twice_area < 0);
            mag_num  = (num < 0) ? -num : num;
            mag_area = (twice_area < 0) ? -twice_area : twice_area;
            if (mag_num == 0) begin
               res.k[i*3+j] = '0;
            end else begin
               quo = ((mag_num << 17) + (mag_area << 1)) / (mag_area << 2);
               if (negative)
                  res.k[i*3+j] = (quo > 64'sh8000_0000) ? SAT_NEG : OUT_WIDTH'(-quo);
               else
                  res.k[i*3+j] = (quo > 64'sh7FFF_FFFF) ? SAT_POS : OUT_WIDTH'(quo);
            end
         end
      end
      return res;
   endfunction

   // Holds the matrices still owed by the block, oldest first, and compares
   // each response against the oldest one.
   class stiffness_scoreboard;
      stiffness_type owed_matrices [$];
      int            mismatches;

      function new();
         mismatches = 0;
      endfunction

      function void note_request(triangle_type t);
         owed_matrices.push_back(stiffness_of(t));
      endfunction

      task report_mismatch(string what, longint got, longint want);
         $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
         mismatches++;
      endtask

      task check_response(stiffness_type got);
         stiffness_type want;
         if (owed_matrices.size() == 0) begin
            report_mismatch("response with no request outstanding, count", 1, 0);
            return;
         end
         want = owed_matrices.pop_front();
         for (int e = 0; e < 9; e++)
            if (got.k[e] !== want.k[e])
               report_mismatch($sformatf("k%0d%0d", e / 3, e % 3), got.k[e], want.k[e]);
         if (got.degenerate !== want.degenerate)
            report_mismatch("degenerate", got.degenerate, want.degenerate);
      endtask
   endclass

   logic clock;
   logic reset;

   tse_req_if #(.COORD_WIDTH(CW)) req ();
   tse_rsp_if                     rsp ();

   triangle_element_stiffness #(.COORD_WIDTH(CW)) uut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   stiffness_scoreboard scoreboard;
   int  requests_sent;
   int  responses_seen;
   int  idle_cycles;
   bit  stimulus_done;

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Every handshake is sampled right after the edge, when the values seen
   // are still those from before it, since all driving is nonblocking.
   always @(posedge clock) begin
      stiffness_type got;
      if (!reset && rsp.valid && rsp.ready) begin
         got.k[0] = rsp.k00; got.k[1] = rsp.k01; got.k[2] = rsp.k02;
         got.k[3] = rsp.k10; got.k[4] = rsp.k11; got.k[5] = rsp.k12;
         got.k[6] = rsp.k20; got.k[7] = rsp.k21; got.k[8] = rsp.k22;
         got.degenerate = rsp.degenerate;
         scoreboard.check_response(got);
         responses_seen++;
      end
   end

   // The watchdog only counts cycles in which neither channel moves.
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Receiver: cycles through fully open, random and mostly stalled modes.
   // Once, after HOLD_AT responses, it holds ready low for the HOLD_CYCLES
   // hold-off while the sender keeps offering, so the pipeline fills and stalls req.
   initial begin
      int mode;
      int span;
      bit held;
      held = 0;
      rsp.ready <= 1'b0;
      @(negedge reset);
      forever begin
         mode = $urandom_range(0, 2);
         span = $urandom_range(20, 150);
         for (int c = 0; c < span; c++) begin
            @(posedge clock);
            if (!held && responses_seen >= HOLD_AT) begin
               held = 1;
               rsp.ready <= 1'b0;
               for (int h = 0; h < HOLD_CYCLES; h++)
                  @(posedge clock);
            end
            case (mode)
               0: rsp.ready <= 1'b1;
               1: rsp.ready <= $urandom_range(0, 1);
               default: rsp.ready <= ($urandom_range(0, 5) == 0);
            endcase
         end
      end
   end

   // Offers one triangle and waits for it to be taken. Valid stays high
   // when the next request follows back to back.
   task automatic send_triangle(triangle_type t);
      req.valid <= 1'b1;
      req.x0 <= t.x0; req.y0 <= t.y0;
      req.x1 <= t.x1; req.y1 <= t.y1;
      req.x2 <= t.x2; req.y2 <= t.y2;
      do
         @(posedge clock);
      while (!req.ready);
      scoreboard.note_request(t);
      requests_sent++;
   endtask

   task automatic idle_sender(int cycles);
      if (cycles > 0) begin
         req.valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   function automatic triangle_type build_triangle(int a, int b, int c, int d, int e, int f);
      triangle_type t;
      t.x0 = CW'(a); t.y0 = CW'(b);
      t.x1 = CW'(c); t.y1 = CW'(d);
      t.x2 = CW'(e); t.y2 = CW'(f);
      return t;
   endfunction

   // Random triangle drawn from one of several families: full range,
   // small well-shaped ones, collinear or repeated vertices, and slivers
   // with long edges and tiny area that drive entries into saturation.
   function automatic triangle_type random_triangle();
      int kind, ax, ay, dx, dy, s;
      kind = $urandom_range(0, 99);
      ax = $urandom_range(0, 65535) - 32768;
      ay = $urandom_range(0, 65535) - 32768;
      if (kind < 40) begin
         return build_triangle(ax, ay, $urandom, $urandom, $urandom, $urandom);
      end else if (kind < 70) begin
         return build_triangle(ax, ay,
                               ax + $urandom_range(0, 1024) - 512,
                               ay + $urandom_range(0, 1024) - 512,
                               ax + $urandom_range(0, 1024) - 512,
                               ay + $urandom_range(0, 1024) - 512);
      end else if (kind < 85) begin
         dx = $urandom_range(0, 200) - 100;
         dy = $urandom_range(0, 200) - 100;
         s  = $urandom_range(0, 6) - 3;
         return build_triangle(ax, ay, ax + dx, ay + dy, ax + s * dx, ay + s * dy);
      end else begin
         dx = $urandom_range(0, 60000) - 30000;
         dy = $urandom_range(0, 60000) - 30000;
         return build_triangle(ax, ay, ax + dx, ay + dy,
                               ax + $urandom_range(0, 2) - 1,
                               ay + $urandom_range(0, 2) - 1);
      end
   endfunction

   initial begin
      triangle_type directed [$];
      int           burst, gap;
      scoreboard     = new();
      requests_sent  = 0;
      responses_seen = 0;
      stimulus_done  = 0;
      reset      <= 1'b1;
      req.valid  <= 1'b0;
      req.x0 <= '0; req.y0 <= '0; req.x1 <= '0;
      req.y1 <= '0; req.x2 <= '0; req.y2 <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // All vertices at the origin: zero area.
      directed.push_back(build_triangle(0, 0, 0, 0, 0, 0));
      // Right triangle with legs of 256 in both windings; the clockwise one negates.
      directed.push_back(build_triangle(0, 0, 256, 0, 0, 256));
      directed.push_back(build_triangle(0, 0, 0, 256, 256, 0));
      // Largest triangles the coordinate range allows, both windings.
      directed.push_back(build_triangle(-32768, -32768, 32767, -32768, -32768, 32767));
      directed.push_back(build_triangle(-32768, -32768, -32768, 32767, 32767, -32768));
      directed.push_back(build_triangle(32767, 32767, -32768, 32767, 32767, -32768));
      // Collinear points and a repeated vertex: degenerate.
      directed.push_back(build_triangle(-32768, -32768, 0, 0, 32767, 32767));
      directed.push_back(build_triangle(100, -7, 100, -7, 5000, 3));
      // Thin slivers with long edges saturate both ways.
      directed.push_back(build_triangle(-32768, 0, 32767, 1, 32767, 0));
      directed.push_back(build_triangle(-32768, 0, 32767, 0, 32767, 1));
      directed.push_back(build_triangle(-32768, -32768, 32767, 32767, 32767, 32766));
      // Smallest nonzero areas and cases that need rounding.
      directed.push_back(build_triangle(0, 0, 1, 0, 0, 1));
      directed.push_back(build_triangle(0, 0, 3, 0, 1, 7));
      directed.push_back(build_triangle(-1, -1, -2, -1, -1, -3));
      directed.push_back(build_triangle(32767, 32767, 32766, 32767, 32767, 32766));
      directed.push_back(build_triangle(-32768, 32767, 1, 2, -3, 4));
      foreach (directed[i])
         send_triangle(directed[i]);

      for (int n = 0; n < NUM_RANDOM; n += burst) begin
         burst = $urandom_range(1, 24);
         for (int b = 0; b < burst; b++)
            send_triangle(random_triangle());
         // About a third of the bursts run straight into the next one.
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         idle_sender(gap);
      end
      req.valid <= 1'b0;
      stimulus_done = 1;

      while (scoreboard.owed_matrices.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (scoreboard.mismatches == 0 && scoreboard.owed_matrices.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
